### hw/rtl/safr_pkg.sv
// package for the aspect-fit rectangle placer: payload structs, codes,
// divider stage types and widths; no dependencies
`default_nettype none
package safr_pkg;

   localparam int WORD_W = 32;
   localparam int DIFF_W = WORD_W + 1;
   localparam int PROD_W = 2 * WORD_W - 1;
   localparam int DVS_W = WORD_W - 1;
   localparam int DIV_BITS = 42;
   localparam int DIM_W = 41;
   localparam int POS_W = 45;
   localparam logic [DIV_BITS-1:0] DIM_CLAMP = DIV_BITS'(1) << (DIM_W - 1);

   localparam int CSR_IDX_W = 2;
   localparam int CSR_DATA_W = 2;
   localparam logic [CSR_IDX_W-1:0] CSR_SCALE_MODE = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_H_ALIGN = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_V_ALIGN = 2'd2;

   localparam logic [1:0] MODE_NONE = 2'd0;
   localparam logic [1:0] MODE_STRETCH = 2'd1;
   localparam logic [1:0] MODE_CONTAIN = 2'd2;
   localparam logic [1:0] MODE_COVER = 2'd3;

   localparam logic [1:0] ALIGN_NEAR = 2'd0;
   localparam logic [1:0] ALIGN_MID = 2'd1;
   localparam logic [1:0] ALIGN_FAR = 2'd2;

   typedef struct packed {
      logic signed [WORD_W-1:0] dst_left;
      logic signed [WORD_W-1:0] dst_top;
      logic signed [WORD_W-1:0] dst_right;
      logic signed [WORD_W-1:0] dst_bottom;
      logic signed [WORD_W-1:0] src_width;
      logic signed [WORD_W-1:0] src_height;
   } req_type;

   typedef struct packed {
      logic                     ok;
      logic signed [WORD_W-1:0] out_left;
      logic signed [WORD_W-1:0] out_top;
      logic signed [WORD_W-1:0] out_right;
      logic signed [WORD_W-1:0] out_bottom;
   } rsp_type;

   typedef struct packed {
      req_type geo;
      logic    use_h;
      logic    ok;
   } meta_type;

   typedef struct packed {
      meta_type            meta;
      logic [DVS_W-1:0]    rem;
      logic [DIV_BITS-1:0] num;
      logic [DIV_BITS-1:0] quo;
      logic [DVS_W-1:0]    dvs;
      logic                ovf;
   } div_type;

endpackage
`default_nettype wire

### hw/rtl/scale_align_fit_rectangle.sv
// aspect-fit rectangle placer top level: mode/alignment registers, product
// compare, pipelined restoring divider and placement; depends on safr_pkg
`default_nettype none
// usage
//   req_*: destination rectangle and source size, one item per valid/ready
//   rsp_*: ok flag and placed rectangle, one item per input item, in order
//   csr_*: register writes (scale mode, h align, v align), always ready;
//          write only while no item is in flight
// stages in order: sizes, products, divider setup, divider, placement, output
// throughput: one item per cycle unless stalled; the divider makes one quotient
//   bit per stage over 42 stages, products and placement take their own stages
// reset: registers return to none / left / top, pipeline empties
// stall: while a result waits on rsp_ready the whole pipeline holds and
//   req_ready drops; nothing is lost or repeated
module scale_align_fit_rectangle (
   input  wire                                   clock,
   input  wire                                   reset,
   input  wire                                   req_valid,
   output logic                                  req_ready,
   input  safr_pkg::req_type                     req_data,
   output logic                                  rsp_valid,
   input  wire                                   rsp_ready,
   output safr_pkg::rsp_type                     rsp_data,
   input  wire                                   csr_valid,
   output logic                                  csr_ready,
   input  wire [safr_pkg::CSR_IDX_W-1:0]         csr_index,
   input  wire [safr_pkg::CSR_DATA_W-1:0]        csr_wdata
);
   import safr_pkg::*;

   function automatic logic signed [WORD_W-1:0] sat_word(input logic signed [POS_W-1:0] v);
      logic signed [POS_W-1:0] hi;
      logic signed [POS_W-1:0] lo;
      hi = POS_W'(signed'({1'b0, {(WORD_W-1){1'b1}}}));
      lo = -hi - POS_W'(1);
      if (v > hi) return {1'b0, {(WORD_W-1){1'b1}}};
      if (v < lo) return {1'b1, {(WORD_W-1){1'b0}}};
      return v[WORD_W-1:0];
   endfunction

   logic [1:0] mode_ff, halign_ff, valign_ff;
   logic       adv;

   assign csr_ready = 1'b1;
   assign adv = !rsp_valid || rsp_ready;
   assign req_ready = adv;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= MODE_NONE;
         halign_ff <= ALIGN_NEAR;
         valign_ff <= ALIGN_NEAR;
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_SCALE_MODE: mode_ff <= csr_wdata;
            CSR_H_ALIGN:    halign_ff <= csr_wdata;
            CSR_V_ALIGN:    valign_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // stage 1: sizes and validity
   logic                     s1_valid_ff;
   req_type                  s1_geo_ff;
   logic signed [DIFF_W-1:0] s1_dw_ff, s1_dh_ff;
   logic                     s1_ok_ff;
   logic signed [DIFF_W-1:0] dw_in, dh_in;
   logic                     ok_in;

   assign dw_in = DIFF_W'(req_data.dst_right) - DIFF_W'(req_data.dst_left);
   assign dh_in = DIFF_W'(req_data.dst_bottom) - DIFF_W'(req_data.dst_top);
   assign ok_in = (req_data.src_width > 0) && (req_data.src_height > 0) &&
                  (dw_in > 0) && (dh_in > 0);

   always_ff @(posedge clock) begin
      if (reset) s1_valid_ff <= 1'b0;
      else if (adv) s1_valid_ff <= req_valid;
      if (adv) begin
         s1_geo_ff <= req_data;
         s1_dw_ff <= dw_in;
         s1_dh_ff <= dh_in;
         s1_ok_ff <= ok_in;
      end
   end

   // stage 2: cross products
   logic              s2_valid_ff;
   meta_type          s2_meta_ff;
   logic [PROD_W-1:0] s2_p_ff, s2_q_ff;

   always_ff @(posedge clock) begin
      if (reset) s2_valid_ff <= 1'b0;
      else if (adv) s2_valid_ff <= s1_valid_ff;
      if (adv) begin
         s2_meta_ff.geo <= s1_geo_ff;
         s2_meta_ff.ok <= s1_ok_ff;
         s2_meta_ff.use_h <= 1'b0;
         s2_p_ff <= PROD_W'(s1_dw_ff[WORD_W-1:0] * s1_geo_ff.src_height[DVS_W-1:0]);
         s2_q_ff <= PROD_W'(s1_dh_ff[WORD_W-1:0] * s1_geo_ff.src_width[DVS_W-1:0]);
      end
   end

   // stage 3: axis choice, divider setup
   div_type             div_ff [0:DIV_BITS];
   logic                dvalid_ff [0:DIV_BITS];
   logic                use_h_in;
   logic [PROD_W-1:0]   num_in;
   logic [DVS_W-1:0]    dvs_in;
   logic [PROD_W-DIV_BITS-1:0] top_in;

   assign use_h_in = (mode_ff == MODE_CONTAIN) ? (s2_p_ff > s2_q_ff) : (s2_p_ff < s2_q_ff);
   assign num_in = use_h_in ? s2_q_ff : s2_p_ff;
   assign dvs_in = use_h_in ? s2_meta_ff.geo.src_height[DVS_W-1:0]
                            : s2_meta_ff.geo.src_width[DVS_W-1:0];
   assign top_in = num_in[PROD_W-1:DIV_BITS];

   always_ff @(posedge clock) begin
      if (reset) dvalid_ff[0] <= 1'b0;
      else if (adv) dvalid_ff[0] <= s2_valid_ff;
      if (adv) begin
         div_ff[0].meta.geo <= s2_meta_ff.geo;
         div_ff[0].meta.ok <= s2_meta_ff.ok;
         div_ff[0].meta.use_h <= use_h_in;
         div_ff[0].rem <= DVS_W'(top_in);
         div_ff[0].num <= num_in[DIV_BITS-1:0];
         div_ff[0].quo <= '0;
         div_ff[0].dvs <= dvs_in;
         div_ff[0].ovf <= DVS_W'(top_in) >= dvs_in;
      end
   end

   // divider: one quotient bit per stage
   for (genvar k = 1; k <= DIV_BITS; k++) begin : g_div
      logic [DVS_W:0] trial;
      logic           ge;
      div_type        stage_in;
      always_comb begin
         trial = {div_ff[k-1].rem, div_ff[k-1].num[DIV_BITS-k]};
         ge = trial >= {1'b0, div_ff[k-1].dvs};
         stage_in = div_ff[k-1];
         stage_in.rem = ge ? DVS_W'(trial - {1'b0, div_ff[k-1].dvs}) : trial[DVS_W-1:0];
         stage_in.quo = {div_ff[k-1].quo[DIV_BITS-2:0], ge};
      end
      always_ff @(posedge clock) begin
         if (reset) dvalid_ff[k] <= 1'b0;
         else if (adv) dvalid_ff[k] <= dvalid_ff[k-1];
         if (adv) div_ff[k] <= stage_in;
      end
   end

   // placement stage
   div_type                  dq;
   logic [DIM_W-1:0]         qdim;
   logic signed [POS_W-1:0]  tw_in, th_in, px_in, py_in;
   logic signed [POS_W-1:0]  l_w, t_w, r_w, b_w;
   logic [1:0]               hsel, vsel;
   logic                     pa_valid_ff, pa_ok_ff;
   logic signed [POS_W-1:0]  pa_x_ff, pa_y_ff, pa_tw_ff, pa_th_ff;

   always_comb begin
      dq = div_ff[DIV_BITS];
      qdim = (dq.ovf || dq.quo > DIM_CLAMP) ? DIM_CLAMP[DIM_W-1:0] : dq.quo[DIM_W-1:0];
      l_w = POS_W'(dq.meta.geo.dst_left);
      t_w = POS_W'(dq.meta.geo.dst_top);
      r_w = POS_W'(dq.meta.geo.dst_right);
      b_w = POS_W'(dq.meta.geo.dst_bottom);
      hsel = halign_ff;
      vsel = valign_ff;
      case (mode_ff)
         MODE_NONE: begin
            tw_in = POS_W'(dq.meta.geo.src_width);
            th_in = POS_W'(dq.meta.geo.src_height);
         end
         MODE_STRETCH: begin
            tw_in = r_w - l_w;
            th_in = b_w - t_w;
            hsel = ALIGN_NEAR;
            vsel = ALIGN_NEAR;
         end
         default: begin
            if (dq.meta.use_h) begin
               tw_in = POS_W'(signed'({1'b0, qdim}));
               th_in = b_w - t_w;
            end else begin
               tw_in = r_w - l_w;
               th_in = POS_W'(signed'({1'b0, qdim}));
            end
         end
      endcase
      case (hsel)
         ALIGN_MID: px_in = l_w + ((r_w - l_w - tw_in) >>> 1);
         ALIGN_FAR: px_in = r_w - tw_in;
         default:   px_in = l_w;
      endcase
      case (vsel)
         ALIGN_MID: py_in = t_w + ((b_w - t_w - th_in) >>> 1);
         ALIGN_FAR: py_in = b_w - th_in;
         default:   py_in = t_w;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) pa_valid_ff <= 1'b0;
      else if (adv) pa_valid_ff <= dvalid_ff[DIV_BITS];
      if (adv) begin
         pa_ok_ff <= dq.meta.ok;
         pa_x_ff <= px_in;
         pa_y_ff <= py_in;
         pa_tw_ff <= tw_in;
         pa_th_ff <= th_in;
      end
   end

   // output register
   logic    rsp_valid_ff;
   rsp_type rsp_ff, rsp_in;

   always_comb begin
      rsp_in.ok = pa_ok_ff;
      rsp_in.out_left = sat_word(pa_x_ff);
      rsp_in.out_top = sat_word(pa_y_ff);
      rsp_in.out_right = sat_word(pa_x_ff + pa_tw_ff);
      rsp_in.out_bottom = sat_word(pa_y_ff + pa_th_ff);
      if (!pa_ok_ff) rsp_in = '0;
   end

   always_ff @(posedge clock) begin
      if (reset) rsp_valid_ff <= 1'b0;
      else if (adv) rsp_valid_ff <= pa_valid_ff;
      if (adv) rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data = rsp_ff;

   a_bad_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.ok |-> rsp_data.out_left == 0 && rsp_data.out_top == 0 &&
      rsp_data.out_right == 0 && rsp_data.out_bottom == 0)
      else $error("invalid item has nonzero edges");
   a_ordered: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.ok |-> rsp_data.out_right >= rsp_data.out_left &&
      rsp_data.out_bottom >= rsp_data.out_top)
      else $error("placed rectangle inverted");
   a_hold: assert property (@(posedge clock) disable iff (reset)
      !adv |=> $stable(pa_valid_ff) && $stable(dvalid_ff[DIV_BITS]) && $stable(s1_valid_ff))
      else $error("pipeline moved during stall");
   a_reset: assert property (@(posedge clock) reset |=> !rsp_valid && !pa_valid_ff)
      else $error("pipeline not empty after reset");

endmodule
`default_nettype wire

### bench/scale_align_fit_rectangle_tb.sv
// self-checking bench for the aspect-fit rectangle placer: random and directed
// rectangles under every mode and alignment; depends on safr_pkg and the top level
`default_nettype none
module scale_align_fit_rectangle_tb;
   import safr_pkg::*;

   localparam int CYCLE_LIMIT = 2000000;
   localparam int LATENCY = 47;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   req_type req_data = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   rsp_type rsp_data;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   logic [1:0] cur_mode = MODE_NONE;
   logic [1:0] cur_halign = ALIGN_NEAR;
   logic [1:0] cur_valign = ALIGN_NEAR;
   rsp_type placed_q[$];
   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   int errors = 0;
   longint cycles = 0;

   scale_align_fit_rectangle i_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data),
      .csr_valid(csr_valid), .csr_ready(csr_ready),
      .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic logic [31:0] clip_word(longint v);
      if (v > 64'sd2147483647) return 32'h7fffffff;
      if (v < -64'sd2147483648) return 32'h80000000;
      return v[31:0];
   endfunction

   function automatic longint align_pos(longint lo, longint hi, longint size,
                                        logic [1:0] sel);
      longint d;
      d = hi - lo - size;
      if (sel == ALIGN_MID) return lo + ((d < 0) ? (d - 1) / 2 : d / 2);
      if (sel == ALIGN_FAR) return hi - size;
      return lo;
   endfunction

   function automatic longint scale_dim(longint a, longint b, longint c);
      logic [127:0] q;
      q = (128'(a) * 128'(b)) / 128'(c);
      if (q > (128'd1 << 40)) q = 128'd1 << 40;
      return longint'(q[63:0]);
   endfunction

   function automatic rsp_type place_rect(req_type r);
      rsp_type o;
      longint l, t, rt, b, sw, sh, dw, dh, tw, th, x, y;
      logic [127:0] p, q;
      logic use_h;
      l = r.dst_left; t = r.dst_top; rt = r.dst_right; b = r.dst_bottom;
      sw = r.src_width; sh = r.src_height;
      dw = rt - l; dh = b - t;
      o = '0;
      if (sw <= 0 || sh <= 0 || dw <= 0 || dh <= 0) return o;
      o.ok = 1'b1;
      if (cur_mode == MODE_STRETCH) begin
         o.out_left = clip_word(l); o.out_top = clip_word(t);
         o.out_right = clip_word(rt); o.out_bottom = clip_word(b);
         return o;
      end
      tw = sw; th = sh;
      if (cur_mode == MODE_CONTAIN || cur_mode == MODE_COVER) begin
         p = 128'(dw) * 128'(sh);
         q = 128'(dh) * 128'(sw);
         use_h = (cur_mode == MODE_CONTAIN) ? (p > q) : (p < q);
         if (use_h) begin
            th = dh; tw = scale_dim(sw, dh, sh);
         end else begin
            tw = dw; th = scale_dim(sh, dw, sw);
         end
      end
      x = align_pos(l, rt, tw, cur_halign);
      y = align_pos(t, b, th, cur_valign);
      o.out_left = clip_word(x); o.out_top = clip_word(y);
      o.out_right = clip_word(x + tw); o.out_bottom = clip_word(y + th);
      return o;
   endfunction

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("FAILURE");
         $finish;
      end
      if (!reset) begin
         rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
         if (rsp_valid && rsp_ready) begin
            if (placed_q.size() == 0) begin
               $display("%0t unexpected item %h", $time, rsp_data);
               errors <= errors + 1;
            end else if (placed_q[0] !== rsp_data) begin
               $display("%0t mismatch expected %h actual %h", $time, placed_q[0], rsp_data);
               errors <= errors + 1;
               void'(placed_q.pop_front());
            end else begin
               void'(placed_q.pop_front());
            end
         end
      end
   end

   task automatic send_rect(req_type r);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= r;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      placed_q.push_back(place_rect(r));
   endtask

   task automatic drain_wait();
      req_valid <= 1'b0;
      while (placed_q.size() != 0) @(posedge clock);
      repeat (LATENCY + 5) @(posedge clock);
   endtask

   task automatic write_reg(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      if (idx == CSR_SCALE_MODE) cur_mode = val;
      else if (idx == CSR_H_ALIGN) cur_halign = val;
      else if (idx == CSR_V_ALIGN) cur_valign = val;
   endtask

   task automatic set_placement(logic [1:0] m, logic [1:0] h, logic [1:0] v);
      drain_wait();
      write_reg(CSR_SCALE_MODE, m);
      write_reg(CSR_H_ALIGN, h);
      write_reg(CSR_V_ALIGN, v);
      csr_valid <= 1'b0;
   endtask

   function automatic logic [31:0] rand_coord();
      case ($urandom_range(5))
         0: return $urandom;
         1: return 32'($signed($urandom_range(4000)) - 2000);
         2: return {$urandom_range(1) ? 16'hffff : 16'h0000, 16'($urandom)};
         3: return $urandom_range(1) ? 32'h7fffffff : 32'h80000000;
         default: return 32'($signed($urandom_range(200000)) - 100000) << 8;
      endcase
   endfunction

   function automatic logic [31:0] rand_size();
      case ($urandom_range(7))
         0: return $urandom;
         1: return $urandom_range(1) ? 32'd1 : 32'h7fffffff;
         2: return $urandom_range(3) == 0 ? 32'd0 : -32'sd1;
         3: return $urandom_range(16);
         default: return 32'($urandom_range(1 << 26, 1));
      endcase
   endfunction

   function automatic req_type rand_rect();
      req_type r;
      logic [31:0] w, h;
      r.dst_left = rand_coord();
      r.dst_top = rand_coord();
      if ($urandom_range(9) < 8) begin
         w = rand_size(); h = rand_size();
         r.dst_right = r.dst_left + w;
         r.dst_bottom = r.dst_top + h;
      end else begin
         r.dst_right = rand_coord();
         r.dst_bottom = rand_coord();
      end
      r.src_width = rand_size();
      r.src_height = rand_size();
      return r;
   endfunction

   task automatic test_directed();
      req_type r;
      for (int m = 0; m < 4; m++) begin
         set_placement(m[1:0], 2'(m % 3), 2'((m + 1) % 3));
         r = '{0, 0, 32'h00640000, 32'h00320000, 32'h00100000, 32'h00100000};
         send_rect(r);
         r = '{32'h80000000, 32'h80000000, 32'h7fffffff, 32'h7fffffff, 1, 1};
         send_rect(r);
         r = '{0, 0, 1, 1, 32'h7fffffff, 1};
         send_rect(r);
         r = '{0, 0, 32'h7fffffff, 32'h7fffffff, 1, 32'h7fffffff};
         send_rect(r);
         r = '{10, 10, 10, 20, 5, 5};
         send_rect(r);
         r = '{0, 0, 100, 100, 0, -1};
         send_rect(r);
      end
      set_placement(MODE_CONTAIN, 2'd3, 2'd3);
      r = '{32'h00010000, 32'h00020000, 32'h00400000, 32'h00200000, 3, 7};
      send_rect(r);
   endtask

   task automatic test_random(int n);
      for (int i = 0; i < n; i++) begin
         if (i % 100 == 0)
            set_placement(2'($urandom_range(3)), 2'($urandom_range(3)),
                          2'($urandom_range(3)));
         send_rect(rand_rect());
      end
   endtask

   task automatic test_bad_index();
      drain_wait();
      write_reg(2'd3, 2'd1);
      csr_valid <= 1'b0;
      send_rect(rand_rect());
   endtask

   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_bad_index();
      send_idle_pct = 17; recv_idle_pct = 52;
      test_random(700);
      send_idle_pct = 52; recv_idle_pct = 17;
      test_random(700);
      send_idle_pct = 0; recv_idle_pct = 0;
      test_random(600);
      drain_wait();
      if (errors == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end
endmodule
`default_nettype wire

### filelist.f
hw/rtl/safr_pkg.sv
hw/rtl/scale_align_fit_rectangle.sv
bench/scale_align_fit_rectangle_tb.sv
